// File: rtl/service_id_acl_match_assert.svh
// assertion macros for the service id acl matcher
// depends on a clock named clock and a synchronous active-high reset named reset
`ifndef SERVICE_ID_ACL_MATCH_ASSERT_SVH
`define SERVICE_ID_ACL_MATCH_ASSERT_SVH

// property holds at every clock edge outside reset
`define SIDAM_ASSERT_IMPL(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a property in the next cycle
`define SIDAM_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// File: rtl/sidam_pkg.sv
// shared constants, types and codes for the service id acl matcher
// no dependencies
`timescale 1ns / 1ps

package sidam_pkg;

   localparam int TABLE_COUNT = 64;
   localparam int LIST_DEPTH  = 16;

   localparam int CAID_W = 16;
   localparam int PROV_W = 24;
   localparam int SRV_W  = 16;
   localparam int MASK_W = 64;
   localparam int FUNC_W = 3;
   localparam int KIND_W = 2;
   localparam int TBL_W  = 6;
   localparam int SLOT_W = 4;
   localparam int LEN_IN_W = 5;

   localparam int ADDR_W = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int CNT_W  = $clog2(TABLE_COUNT + 1);
   localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
   localparam int EXT_W  = 8;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [EXT_W-1:0]  ext_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WR_ENTRY = 3'd0,
      FUNC_WR_LEN   = 3'd1,
      FUNC_CHK_FULL = 3'd2,
      FUNC_CHK_CP   = 3'd3,
      FUNC_CHK_SRV  = 3'd4
   } func_type;

   localparam logic [KIND_W-1:0] KIND_CAID = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PROV = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SRV  = 2'd2;

   // one memory row holds a whole rule table
   typedef struct packed {
      logic [LIST_DEPTH-1:0][CAID_W-1:0] caid;
      logic [LIST_DEPTH-1:0][PROV_W-1:0] prov;
      logic [LIST_DEPTH-1:0][SRV_W-1:0]  srv;
      len_type                           len_srv;
      len_type                           len_prov;
      len_type                           len_caid;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   typedef struct packed {
      logic act_full;
      logic act_cp;
      logic has_srv;
      logic hit_c;
      logic hit_p;
      logic hit_s;
   } match_type;

endpackage

// File: rtl/service_id_acl_match.sv
// top level of the service id acl matcher: control, table memory and verdict walk
// depends on sidam_pkg, sidam_ram, sidam_match and service_id_acl_match_assert.svh
`timescale 1ns / 1ps

// rule-table matcher for system, provider and service ids. each of the 64 tables
// sits in one row of a single memory (all three id lists plus the three lengths),
// so one table is read and compared per cycle. a check walks every table
// through the single read port of the table memory and raises the result strobe
// after the last table. entry and length writes read the row, merge the new word
// and write it back: the strobe is registered in the write-back state. func
// codes 5 to 7 answer 0 in the cycle after start without raising busy. busy
// drops in the cycle the strobe shows, so a new word can be started there.
// results are shown for one cycle only and cannot be held off. list lengths
// come up zero after reset through one valid flag per table; id entries are
// undefined until written.

`include "service_id_acl_match_assert.svh"

module service_id_acl_match (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [sidam_pkg::FUNC_W-1:0]     req_func,
   input  logic [sidam_pkg::TBL_W-1:0]      req_table_index,
   input  logic [sidam_pkg::KIND_W-1:0]     req_list_kind,
   input  logic [sidam_pkg::SLOT_W-1:0]     req_slot_index,
   input  logic [sidam_pkg::PROV_W-1:0]     req_entry_value,
   input  logic [sidam_pkg::LEN_IN_W-1:0]   req_length_value,
   input  logic [sidam_pkg::CAID_W-1:0]     req_request_caid,
   input  logic [sidam_pkg::PROV_W-1:0]     req_request_provid,
   input  logic [sidam_pkg::SRV_W-1:0]      req_request_srvid,
   input  logic [sidam_pkg::MASK_W-1:0]     req_allow_mask,
   input  logic [sidam_pkg::MASK_W-1:0]     req_deny_mask,
   output logic                             rsp_strobe,
   output logic                             rsp_accepted
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RMW,
      ST_WALK
   } state_type;

   // control state
   state_type                          state_ff, state_in;
   sidam_pkg::cnt_type                 cnt_ff, cnt_in;
   logic                               acc_ff, acc_in;
   logic                               done_ff, done_in;
   logic [sidam_pkg::TABLE_COUNT-1:0]  vld_ff, vld_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic                               rsp_accepted_ff, rsp_accepted_in;

   // latched request word
   logic [sidam_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic [sidam_pkg::TBL_W-1:0]        tbl_ff, tbl_in;
   logic [sidam_pkg::KIND_W-1:0]       kind_ff, kind_in;
   logic [sidam_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [sidam_pkg::PROV_W-1:0]       val_ff, val_in;
   logic [sidam_pkg::LEN_IN_W-1:0]     len_ff, len_in;
   logic [sidam_pkg::CAID_W-1:0]       caid_ff, caid_in;
   logic [sidam_pkg::PROV_W-1:0]       prov_ff, prov_in;
   logic [sidam_pkg::SRV_W-1:0]        srv_ff, srv_in;
   logic [sidam_pkg::MASK_W-1:0]       allow_ff, allow_in;
   logic [sidam_pkg::MASK_W-1:0]       deny_ff, deny_in;

   // datapath
   logic                               accept;
   logic                               req_is_write;
   logic                               req_tbl_ok;
   logic                               tbl_ok;
   logic                               slot_ok;
   logic                               rd_ok;
   sidam_pkg::addr_type                ram_raddr;
   logic                               ram_we;
   logic [sidam_pkg::ROW_W-1:0]        ram_rdata;
   sidam_pkg::row_type                 row_rd;
   sidam_pkg::row_type                 row_wr;
   sidam_pkg::len_type                 len_sat;
   sidam_pkg::match_type               match;
   logic                               tm_full;
   logic                               tm_cp;
   logic                               acc_eval;
   logic                               done_eval;
   logic                               walk_last;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_accepted = rsp_accepted_ff;

   assign req_is_write = (req_func == sidam_pkg::FUNC_WR_ENTRY) ||
                         (req_func == sidam_pkg::FUNC_WR_LEN);
   assign req_tbl_ok   = sidam_pkg::ext_type'(req_table_index) <
                         sidam_pkg::ext_type'(sidam_pkg::TABLE_COUNT);
   assign tbl_ok       = sidam_pkg::ext_type'(tbl_ff) <
                         sidam_pkg::ext_type'(sidam_pkg::TABLE_COUNT);
   assign slot_ok      = sidam_pkg::ext_type'(slot_ff) <
                         sidam_pkg::ext_type'(sidam_pkg::LIST_DEPTH);
   assign walk_last    = (cnt_ff == sidam_pkg::cnt_type'(sidam_pkg::TABLE_COUNT));

   // read address: the addressed table for a write, table 0 to open a walk,
   // then the walk counter
   always_comb begin
      ram_raddr = '0;
      rd_ok     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ram_raddr = req_is_write ? req_table_index[sidam_pkg::ADDR_W-1:0] : '0;
            rd_ok     = req_is_write ? req_tbl_ok : 1'b1;
         end
         ST_WALK: begin
            ram_raddr = cnt_ff[sidam_pkg::ADDR_W-1:0];
            rd_ok     = !walk_last;
         end
         default: begin
            ram_raddr = '0;
            rd_ok     = 1'b0;
         end
      endcase
   end

   // valid flag travels with the registered read data
   assign rd_vld_in = rd_ok && vld_ff[ram_raddr];

   assign row_rd = ram_rdata;
   assign ram_we = (state_ff == ST_RMW) && tbl_ok;

   sidam_ram #(
      .WIDTH (sidam_pkg::ROW_W),
      .DEPTH (sidam_pkg::TABLE_COUNT)
   ) u_table_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (tbl_ff[sidam_pkg::ADDR_W-1:0]),
      .wdata (row_wr),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sidam_match u_match (
      .row       (row_rd),
      .row_valid (rd_vld_ff),
      .caid      (caid_ff),
      .prov      (prov_ff),
      .srv       (srv_ff),
      .match     (match)
   );

   // lengths above the list depth saturate
   always_comb begin
      if (sidam_pkg::ext_type'(len_ff) > sidam_pkg::ext_type'(sidam_pkg::LIST_DEPTH)) begin
         len_sat = sidam_pkg::len_type'(sidam_pkg::LIST_DEPTH);
      end else begin
         len_sat = sidam_pkg::len_type'(len_ff);
      end
   end

   // merge of the write word into the row read back
   always_comb begin
      row_wr = row_rd;
      if (!rd_vld_ff) begin
         // row never written: lengths are still at their reset value
         row_wr.len_caid = '0;
         row_wr.len_prov = '0;
         row_wr.len_srv  = '0;
      end
      case (func_ff)
         sidam_pkg::FUNC_WR_ENTRY: begin
            for (int s = 0; s < sidam_pkg::LIST_DEPTH; s++) begin
               if (slot_ok && (sidam_pkg::ext_type'(slot_ff) == sidam_pkg::ext_type'(s))) begin
                  case (kind_ff)
                     sidam_pkg::KIND_CAID: row_wr.caid[s] = val_ff[sidam_pkg::CAID_W-1:0];
                     sidam_pkg::KIND_PROV: row_wr.prov[s] = val_ff;
                     sidam_pkg::KIND_SRV:  row_wr.srv[s]  = val_ff[sidam_pkg::SRV_W-1:0];
                     default: ;
                  endcase
               end
            end
         end
         sidam_pkg::FUNC_WR_LEN: begin
            case (kind_ff)
               sidam_pkg::KIND_CAID: row_wr.len_caid = len_sat;
               sidam_pkg::KIND_PROV: row_wr.len_prov = len_sat;
               sidam_pkg::KIND_SRV:  row_wr.len_srv  = len_sat;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // verdict update for the table now on the read port; mask bit 0 belongs to it
   assign tm_full = match.hit_c && match.hit_p && match.hit_s;
   assign tm_cp   = match.hit_c && match.hit_p;

   always_comb begin
      acc_eval  = acc_ff;
      done_eval = done_ff;
      if (!done_ff) begin
         case (func_ff)
            sidam_pkg::FUNC_CHK_FULL: begin
               if (match.act_full) begin
                  if (deny_ff[0] && tm_full) begin
                     acc_eval  = 1'b0;
                     done_eval = 1'b1;
                  end else if (allow_ff[0] && tm_full) begin
                     acc_eval = 1'b1;
                  end
               end
            end
            sidam_pkg::FUNC_CHK_CP: begin
               // deny only counts for tables without a service list
               if (match.act_cp) begin
                  if (deny_ff[0] && !match.has_srv && tm_cp) begin
                     acc_eval  = 1'b0;
                     done_eval = 1'b1;
                  end else if (allow_ff[0] && tm_cp) begin
                     acc_eval = 1'b1;
                  end
               end
            end
            sidam_pkg::FUNC_CHK_SRV: begin
               if (match.has_srv && allow_ff[0] && tm_full) begin
                  acc_eval  = 1'b1;
                  done_eval = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      acc_in          = acc_ff;
      done_in         = done_ff;
      vld_in          = vld_ff;
      rsp_strobe_in   = 1'b0;
      rsp_accepted_in = rsp_accepted_ff;
      func_in         = func_ff;
      tbl_in          = tbl_ff;
      kind_in         = kind_ff;
      slot_in         = slot_ff;
      val_in          = val_ff;
      len_in          = len_ff;
      caid_in         = caid_ff;
      prov_in         = prov_ff;
      srv_in          = srv_ff;
      allow_in        = allow_ff;
      deny_in         = deny_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               tbl_in   = req_table_index;
               kind_in  = req_list_kind;
               slot_in  = req_slot_index;
               val_in   = req_entry_value;
               len_in   = req_length_value;
               caid_in  = req_request_caid;
               prov_in  = req_request_provid;
               srv_in   = req_request_srvid;
               allow_in = req_allow_mask;
               deny_in  = req_deny_mask;
               cnt_in   = sidam_pkg::cnt_type'(1);
               case (req_func)
                  sidam_pkg::FUNC_WR_ENTRY,
                  sidam_pkg::FUNC_WR_LEN: begin
                     state_in = ST_RMW;
                  end
                  sidam_pkg::FUNC_CHK_FULL,
                  sidam_pkg::FUNC_CHK_CP: begin
                     // both masks clear: accept without looking at any table
                     done_in  = (req_allow_mask == '0) && (req_deny_mask == '0);
                     acc_in   = (req_allow_mask == '0);
                     state_in = ST_WALK;
                  end
                  sidam_pkg::FUNC_CHK_SRV: begin
                     done_in  = (req_allow_mask == '0);
                     acc_in   = 1'b0;
                     state_in = ST_WALK;
                  end
                  default: begin
                     // unused codes answer reject at once
                     rsp_strobe_in   = 1'b1;
                     rsp_accepted_in = 1'b0;
                  end
               endcase
            end
         end
         ST_RMW: begin
            for (int t = 0; t < sidam_pkg::TABLE_COUNT; t++) begin
               if (tbl_ok && (sidam_pkg::ext_type'(tbl_ff) == sidam_pkg::ext_type'(t))) begin
                  vld_in[t] = 1'b1;
               end
            end
            rsp_strobe_in   = 1'b1;
            rsp_accepted_in = 1'b0;
            state_in        = ST_IDLE;
         end
         ST_WALK: begin
            acc_in   = acc_eval;
            done_in  = done_eval;
            allow_in = allow_ff >> 1;
            deny_in  = deny_ff >> 1;
            if (walk_last) begin
               rsp_strobe_in   = 1'b1;
               rsp_accepted_in = acc_eval;
               state_in        = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + sidam_pkg::cnt_type'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         acc_ff          <= 1'b0;
         done_ff         <= 1'b0;
         vld_ff          <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         rsp_accepted_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         acc_ff          <= acc_in;
         done_ff         <= done_in;
         vld_ff          <= vld_in;
         rd_vld_ff       <= rd_vld_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         rsp_accepted_ff <= rsp_accepted_in;
      end
   end

   // request word, no reset needed
   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      tbl_ff   <= tbl_in;
      kind_ff  <= kind_in;
      slot_ff  <= slot_in;
      val_ff   <= val_in;
      len_ff   <= len_in;
      caid_ff  <= caid_in;
      prov_ff  <= prov_in;
      srv_ff   <= srv_in;
      allow_ff <= allow_in;
      deny_ff  <= deny_in;
   end

   // checks
   `SIDAM_ASSERT_IMPL(a_strobe_not_busy, rsp_strobe |-> !busy, "result strobe while busy")
   `SIDAM_ASSERT_IMPL(a_accept_from_walk, (rsp_strobe && rsp_accepted) |-> $past(state_ff == ST_WALK), "accept verdict without a table walk")
   `SIDAM_ASSERT_NEXT(a_write_goes_busy, start && !busy && req_is_write, busy && !rsp_strobe, "write word not held for read-modify-write")

endmodule

// File: rtl/sidam_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sidam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/sidam_match.sv
// compares one rule table row against the request ids
// depends on sidam_pkg
`timescale 1ns / 1ps

module sidam_match (
   input  sidam_pkg::row_type                 row,
   input  logic                               row_valid,
   input  logic [sidam_pkg::CAID_W-1:0]       caid,
   input  logic [sidam_pkg::PROV_W-1:0]       prov,
   input  logic [sidam_pkg::SRV_W-1:0]        srv,
   output sidam_pkg::match_type               match
);

   sidam_pkg::len_type lc;
   sidam_pkg::len_type lp;
   sidam_pkg::len_type ls;
   logic               any_c;
   logic               any_p;
   logic               any_s;

   // rows never written read as empty tables
   assign lc = row_valid ? row.len_caid : '0;
   assign lp = row_valid ? row.len_prov : '0;
   assign ls = row_valid ? row.len_srv  : '0;

   always_comb begin
      any_c = 1'b0;
      any_p = 1'b0;
      any_s = 1'b0;
      for (int s = 0; s < sidam_pkg::LIST_DEPTH; s++) begin
         if ((sidam_pkg::ext_type'(s) < sidam_pkg::ext_type'(lc)) && (row.caid[s] == caid)) begin
            any_c = 1'b1;
         end
         if ((sidam_pkg::ext_type'(s) < sidam_pkg::ext_type'(lp)) && (row.prov[s] == prov)) begin
            any_p = 1'b1;
         end
         if ((sidam_pkg::ext_type'(s) < sidam_pkg::ext_type'(ls)) && (row.srv[s] == srv)) begin
            any_s = 1'b1;
         end
      end
   end

   // empty list matches anything
   assign match.hit_c    = (lc == '0) || any_c;
   assign match.hit_p    = (lp == '0) || any_p;
   assign match.hit_s    = (ls == '0) || any_s;
   assign match.has_srv  = (ls != '0);
   assign match.act_cp   = (lc != '0) || (lp != '0);
   assign match.act_full = (lc != '0) || (lp != '0) || (ls != '0);

endmodule

// File: tb/acl_verdict_checker.sv
// verdict checker for the service id acl matcher: watches the command and result ports
// keeps its own copy of the rule tables and predicts every verdict; depends on sidam_pkg
`timescale 1ns / 1ps

module acl_verdict_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [sidam_pkg::FUNC_W-1:0]     req_func,
   input  logic [sidam_pkg::TBL_W-1:0]      req_table_index,
   input  logic [sidam_pkg::KIND_W-1:0]     req_list_kind,
   input  logic [sidam_pkg::SLOT_W-1:0]     req_slot_index,
   input  logic [sidam_pkg::PROV_W-1:0]     req_entry_value,
   input  logic [sidam_pkg::LEN_IN_W-1:0]   req_length_value,
   input  logic [sidam_pkg::CAID_W-1:0]     req_request_caid,
   input  logic [sidam_pkg::PROV_W-1:0]     req_request_provid,
   input  logic [sidam_pkg::SRV_W-1:0]      req_request_srvid,
   input  logic [sidam_pkg::MASK_W-1:0]     req_allow_mask,
   input  logic [sidam_pkg::MASK_W-1:0]     req_deny_mask,
   input  logic                             rsp_strobe,
   input  logic                             rsp_accepted,
   output int                               verdict_errors,
   output int                               verdicts_pending
);
   import sidam_pkg::*;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic              accepted;
   } verdict_type;

   verdict_type         expected_verdicts[$];

   logic [CAID_W-1:0]   caid_rows [TABLE_COUNT][LIST_DEPTH];
   logic [PROV_W-1:0]   prov_rows [TABLE_COUNT][LIST_DEPTH];
   logic [SRV_W-1:0]    srv_rows  [TABLE_COUNT][LIST_DEPTH];
   logic [LEN_IN_W-1:0] list_len  [TABLE_COUNT][3];

   initial begin
      verdict_errors   = 0;
      verdicts_pending = 0;
      for (int t = 0; t < TABLE_COUNT; t++) begin
         for (int k = 0; k < 3; k++) begin
            list_len[t][k] = '0;
         end
      end
   end

   // empty list matches anything
   function automatic logic list_hit(input logic [TBL_W-1:0] t, input logic [KIND_W-1:0] kind,
                                     input logic [PROV_W-1:0] value);
      logic hit;
      hit = (list_len[t][kind] == '0);
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (i < int'(list_len[t][kind])) begin
            case (kind)
               KIND_CAID: if (caid_rows[t][i] == value[CAID_W-1:0]) hit = 1'b1;
               KIND_PROV: if (prov_rows[t][i] == value) hit = 1'b1;
               default:   if (srv_rows[t][i] == value[SRV_W-1:0]) hit = 1'b1;
            endcase
         end
      end
      return hit;
   endfunction

   function automatic logic table_hit(input logic [TBL_W-1:0] t, input logic [CAID_W-1:0] caid,
                                      input logic [PROV_W-1:0] prov, input logic [SRV_W-1:0] srv,
                                      input logic use_srv);
      return list_hit(t, KIND_CAID, PROV_W'(caid)) && list_hit(t, KIND_PROV, prov) &&
             (!use_srv || list_hit(t, KIND_SRV, PROV_W'(srv)));
   endfunction

   // applies one word to the table copy and returns its verdict
   function automatic logic predict_verdict(
      input logic [FUNC_W-1:0]   func,
      input logic [TBL_W-1:0]    t,
      input logic [KIND_W-1:0]   kind,
      input logic [SLOT_W-1:0]   slot,
      input logic [PROV_W-1:0]   value,
      input logic [LEN_IN_W-1:0] len,
      input logic [CAID_W-1:0]   caid,
      input logic [PROV_W-1:0]   prov,
      input logic [SRV_W-1:0]    srv,
      input logic [MASK_W-1:0]   allow,
      input logic [MASK_W-1:0]   deny
   );
      logic                acc;
      logic                full;
      logic                done;
      logic                active;
      logic                srv_empty;
      logic [TBL_W-1:0]    ti;
      logic [LEN_IN_W-1:0] sat;
      acc = 1'b0;
      case (func)
         FUNC_WR_ENTRY: begin
            case (kind)
               KIND_CAID: caid_rows[t][slot] = value[CAID_W-1:0];
               KIND_PROV: prov_rows[t][slot] = value;
               KIND_SRV:  srv_rows[t][slot]  = value[SRV_W-1:0];
               default:   ;
            endcase
         end
         FUNC_WR_LEN: begin
            sat = (int'(len) > LIST_DEPTH) ? LEN_IN_W'(LIST_DEPTH) : len;
            case (kind)
               KIND_CAID, KIND_PROV, KIND_SRV: list_len[t][kind] = sat;
               default: ;
            endcase
         end
         FUNC_CHK_FULL, FUNC_CHK_CP: begin
            full = (func == FUNC_CHK_FULL);
            done = 1'b0;
            if (allow == '0 && deny == '0) begin
               acc  = 1'b1;
               done = 1'b1;
            end else begin
               acc = (allow == '0);
            end
            for (int i = 0; i < TABLE_COUNT; i++) begin
               ti        = TBL_W'(i);
               srv_empty = (list_len[ti][KIND_SRV] == '0);
               active    = (list_len[ti][KIND_CAID] != '0) || (list_len[ti][KIND_PROV] != '0) ||
                           (full && !srv_empty);
               if (!done && active) begin
                  if (deny[i] && (full || srv_empty) &&
                      table_hit(ti, caid, prov, srv, full)) begin
                     acc  = 1'b0;
                     done = 1'b1;
                  end else if (allow[i] && table_hit(ti, caid, prov, srv, full)) begin
                     acc = 1'b1;
                  end
               end
            end
         end
         FUNC_CHK_SRV: begin
            if (allow != '0) begin
               for (int i = 0; i < TABLE_COUNT; i++) begin
                  ti = TBL_W'(i);
                  if (list_len[ti][KIND_SRV] != '0 && allow[i] &&
                      table_hit(ti, caid, prov, srv, 1'b1)) begin
                     acc = 1'b1;
                  end
               end
            end
         end
         default: acc = 1'b0;
      endcase
      return acc;
   endfunction

   always @(posedge clock) begin : watch
      verdict_type want;
      verdict_type fresh;
      if (!reset) begin
         // a result leaving and a new word entering can share one edge
         if (rsp_strobe) begin
            if (expected_verdicts.size() == 0) begin
               $error("accepted: result with no word pending, actual %0b", rsp_accepted);
               verdict_errors++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_accepted !== want.accepted) begin
                  $error("accepted mismatch (func %0d): expected %0b, actual %0b",
                         want.func, want.accepted, rsp_accepted);
                  verdict_errors++;
               end
            end
         end
         if (start && !busy) begin
            fresh.func     = req_func;
            fresh.accepted = predict_verdict(req_func, req_table_index, req_list_kind,
                                             req_slot_index, req_entry_value, req_length_value,
                                             req_request_caid, req_request_provid,
                                             req_request_srvid, req_allow_mask, req_deny_mask);
            expected_verdicts.push_back(fresh);
         end
         verdicts_pending = expected_verdicts.size();
      end
   end

endmodule

// File: tb/tb_top.sv
// top of the service id acl matcher testbench: clock, reset, stimulus and verdict
// depends on sidam_pkg, service_id_acl_match and acl_verdict_checker
`timescale 1ns / 1ps

module tb_top;
   import sidam_pkg::*;

   // list kind that names no list, writes with it change nothing
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
   localparam int FUNC_LAST    = (1 << FUNC_W) - 1;
   localparam int LEN_LAST     = (1 << LEN_IN_W) - 1;
   localparam int WORK_ITEMS   = 600;
   localparam int PAUSE_EVERY  = 150;
   localparam int HOT_TABLES   = 8;
   localparam int POOL         = 4;
   localparam int DRAIN_CYCLES = TABLE_COUNT + 8;
   localparam logic [MASK_W-1:0] HOT_MASK = (MASK_W'(1) << HOT_TABLES) - 1;

   typedef struct {
      logic [FUNC_W-1:0]   func;
      logic [TBL_W-1:0]    table_index;
      logic [KIND_W-1:0]   list_kind;
      logic [SLOT_W-1:0]   slot_index;
      logic [PROV_W-1:0]   entry_value;
      logic [LEN_IN_W-1:0] length_value;
      logic [CAID_W-1:0]   request_caid;
      logic [PROV_W-1:0]   request_provid;
      logic [SRV_W-1:0]    request_srvid;
      logic [MASK_W-1:0]   allow_mask;
      logic [MASK_W-1:0]   deny_mask;
   } acl_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [TBL_W-1:0]    req_table_index = '0;
   logic [KIND_W-1:0]   req_list_kind = '0;
   logic [SLOT_W-1:0]   req_slot_index = '0;
   logic [PROV_W-1:0]   req_entry_value = '0;
   logic [LEN_IN_W-1:0] req_length_value = '0;
   logic [CAID_W-1:0]   req_request_caid = '0;
   logic [PROV_W-1:0]   req_request_provid = '0;
   logic [SRV_W-1:0]    req_request_srvid = '0;
   logic [MASK_W-1:0]   req_allow_mask = '0;
   logic [MASK_W-1:0]   req_deny_mask = '0;
   logic                rsp_strobe;
   logic                rsp_accepted;

   int                  verdict_errors;
   int                  verdicts_pending;

   // which list slots hold a defined id, lengths never reach past these
   bit                  written [TABLE_COUNT][3][LIST_DEPTH];
   // small id pools so that requests hit the programmed tables often
   logic [CAID_W-1:0]   caid_pool [POOL];
   logic [PROV_W-1:0]   prov_pool [POOL];
   logic [SRV_W-1:0]    srv_pool  [POOL];
   int                  burst_left = 0;
   int                  work_done = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   service_id_acl_match dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_table_index    (req_table_index),
      .req_list_kind      (req_list_kind),
      .req_slot_index     (req_slot_index),
      .req_entry_value    (req_entry_value),
      .req_length_value   (req_length_value),
      .req_request_caid   (req_request_caid),
      .req_request_provid (req_request_provid),
      .req_request_srvid  (req_request_srvid),
      .req_allow_mask     (req_allow_mask),
      .req_deny_mask      (req_deny_mask),
      .rsp_strobe         (rsp_strobe),
      .rsp_accepted       (rsp_accepted)
   );

   acl_verdict_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_table_index    (req_table_index),
      .req_list_kind      (req_list_kind),
      .req_slot_index     (req_slot_index),
      .req_entry_value    (req_entry_value),
      .req_length_value   (req_length_value),
      .req_request_caid   (req_request_caid),
      .req_request_provid (req_request_provid),
      .req_request_srvid  (req_request_srvid),
      .req_allow_mask     (req_allow_mask),
      .req_deny_mask      (req_deny_mask),
      .rsp_strobe         (rsp_strobe),
      .rsp_accepted       (rsp_accepted),
      .verdict_errors     (verdict_errors),
      .verdicts_pending   (verdicts_pending)
   );

   // every field random, callers then set the ones that matter
   function automatic acl_word_type random_word();
      acl_word_type w;
      w.func           = FUNC_W'($urandom);
      w.table_index    = TBL_W'($urandom);
      w.list_kind      = KIND_W'($urandom);
      w.slot_index     = SLOT_W'($urandom);
      w.entry_value    = PROV_W'($urandom);
      w.length_value   = LEN_IN_W'($urandom);
      w.request_caid   = CAID_W'($urandom);
      w.request_provid = PROV_W'($urandom);
      w.request_srvid  = SRV_W'($urandom);
      w.allow_mask     = {$urandom, $urandom};
      w.deny_mask      = {$urandom, $urandom};
      return w;
   endfunction

   function automatic acl_word_type entry_word(input int t, input int kind, input int slot,
                                               input logic [PROV_W-1:0] value);
      acl_word_type w;
      w             = random_word();
      w.func        = FUNC_WR_ENTRY;
      w.table_index = TBL_W'(t);
      w.list_kind   = KIND_W'(kind);
      w.slot_index  = SLOT_W'(slot);
      w.entry_value = value;
      return w;
   endfunction

   function automatic acl_word_type length_word(input int t, input int kind, input int len);
      acl_word_type w;
      w              = random_word();
      w.func         = FUNC_WR_LEN;
      w.table_index  = TBL_W'(t);
      w.list_kind    = KIND_W'(kind);
      w.length_value = LEN_IN_W'(len);
      return w;
   endfunction

   function automatic acl_word_type check_word(input logic [FUNC_W-1:0] func,
                                               input logic [CAID_W-1:0] caid,
                                               input logic [PROV_W-1:0] prov,
                                               input logic [SRV_W-1:0] srv,
                                               input logic [MASK_W-1:0] allow,
                                               input logic [MASK_W-1:0] deny);
      acl_word_type w;
      w                = random_word();
      w.func           = func;
      w.request_caid   = caid;
      w.request_provid = prov;
      w.request_srvid  = srv;
      w.allow_mask     = allow;
      w.deny_mask      = deny;
      return w;
   endfunction

   // number of defined slots from slot zero up
   function automatic int fill_depth(input int t, input int kind);
      int d;
      d = 0;
      while (d < LIST_DEPTH && written[t][kind][d]) d++;
      return d;
   endfunction

   // masks lean on the low tables, where most lists get programmed
   function automatic logic [MASK_W-1:0] pick_mask();
      logic [MASK_W-1:0] m;
      case ($urandom_range(0, 6))
         0:       m = '0;
         1:       m = '1;
         2:       m = {$urandom, $urandom};
         3:       m = MASK_W'(1) << $urandom_range(0, TABLE_COUNT - 1);
         4, 5:    m = {$urandom, $urandom} & HOT_MASK;
         default: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      return m;
   endfunction

   // id for a list entry: mostly from the pools, upper bits random for the 16-bit lists
   function automatic logic [PROV_W-1:0] pool_entry(input int kind);
      int                          i;
      logic [PROV_W-CAID_W-1:0]    upper;
      logic [PROV_W-1:0]           v;
      i     = $urandom_range(0, POOL - 1);
      upper = (PROV_W-CAID_W)'($urandom);
      if ($urandom_range(0, 9) == 0) v = PROV_W'($urandom);
      else if (kind == KIND_CAID) v = {upper, caid_pool[i]};
      else if (kind == KIND_PROV) v = prov_pool[i];
      else v = {upper, srv_pool[i]};
      return v;
   endfunction

   function automatic acl_word_type random_check();
      logic [FUNC_W-1:0] func;
      logic [CAID_W-1:0] caid;
      logic [PROV_W-1:0] prov;
      logic [SRV_W-1:0]  srv;
      logic [MASK_W-1:0] deny;
      case ($urandom_range(0, 2))
         0:       func = FUNC_CHK_FULL;
         1:       func = FUNC_CHK_CP;
         default: func = FUNC_CHK_SRV;
      endcase
      caid = ($urandom_range(0, 9) < 8) ? caid_pool[$urandom_range(0, POOL - 1)]
                                        : CAID_W'($urandom);
      prov = ($urandom_range(0, 9) < 8) ? prov_pool[$urandom_range(0, POOL - 1)]
                                        : PROV_W'($urandom);
      srv  = ($urandom_range(0, 9) < 8) ? srv_pool[$urandom_range(0, POOL - 1)]
                                        : SRV_W'($urandom);
      // a quiet deny mask lets allow hits show up
      deny = ($urandom_range(0, 9) < 4) ? '0 : pick_mask();
      return check_word(func, caid, prov, srv, pick_mask(), deny);
   endfunction

   // drives one word and holds it until the block takes it
   task automatic send_word(input acl_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
         // start only drops when there is a real gap, never lowered and raised in one step
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_func           <= w.func;
      req_table_index    <= w.table_index;
      req_list_kind      <= w.list_kind;
      req_slot_index     <= w.slot_index;
      req_entry_value    <= w.entry_value;
      req_length_value   <= w.length_value;
      req_request_caid   <= w.request_caid;
      req_request_provid <= w.request_provid;
      req_request_srvid  <= w.request_srvid;
      req_allow_mask     <= w.allow_mask;
      req_deny_mask      <= w.deny_mask;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
      if (w.func == FUNC_WR_ENTRY && w.list_kind != KIND_NONE) begin
         written[w.table_index][w.list_kind][w.slot_index] = 1'b1;
      end
      // words the block only ignores are not counted as work
      if (!(w.func > FUNC_CHK_SRV ||
            ((w.func == FUNC_WR_ENTRY || w.func == FUNC_WR_LEN) && w.list_kind == KIND_NONE))) begin
         work_done++;
      end
   endtask

   // sender stays quiet until every verdict is back, pending is sampled mid cycle
   task automatic wait_quiet();
      start <= 1'b0;
      do @(negedge clock); while (verdicts_pending != 0);
      @(posedge clock);
   endtask

   // well-formed table load: entries first, then the lengths that cover them
   task automatic program_table();
      int t;
      int n;
      int len;
      t = ($urandom_range(0, 3) != 0) ? $urandom_range(0, HOT_TABLES - 1)
                                      : $urandom_range(0, TABLE_COUNT - 1);
      for (int k = 0; k < 3; k++) begin
         n = ($urandom_range(0, 7) == 0) ? LIST_DEPTH : $urandom_range(0, 3);
         for (int s = 0; s < n; s++) send_word(entry_word(t, k, s, pool_entry(k)));
         len = n;
         // full list may take an oversize length, which saturates
         if (n == LIST_DEPTH && $urandom_range(0, 1) == 1) len = $urandom_range(LIST_DEPTH, LEN_LAST);
         send_word(length_word(t, k, len));
      end
   endtask

   // stray writes, ignored list kind and unused func codes
   task automatic send_noise();
      acl_word_type w;
      int           depth;
      w = random_word();
      case ($urandom_range(0, 3))
         0: w.func = FUNC_WR_ENTRY;
         1: begin
            w.func = FUNC_WR_LEN;
            if (w.list_kind != KIND_NONE) begin
               depth = fill_depth(w.table_index, w.list_kind);
               w.length_value = (depth == LIST_DEPTH) ? LEN_IN_W'($urandom_range(0, LEN_LAST))
                                                      : LEN_IN_W'($urandom_range(0, depth));
            end
         end
         2: begin
            w.func      = ($urandom_range(0, 1) == 0) ? FUNC_WR_ENTRY : FUNC_WR_LEN;
            w.list_kind = KIND_NONE;
         end
         default: w.func = FUNC_W'($urandom_range(FUNC_CHK_SRV + 1, FUNC_LAST));
      endcase
      send_word(w);
   endtask

   initial begin
      int next_pause;
      for (int i = 0; i < POOL; i++) begin
         caid_pool[i] = CAID_W'($urandom);
         prov_pool[i] = PROV_W'($urandom);
         srv_pool[i]  = SRV_W'($urandom);
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty tables: both masks zero, deny only, allow only, service check with no allow
      send_word(check_word(FUNC_CHK_FULL, caid_pool[0], prov_pool[0], srv_pool[0], '0, '0));
      send_word(check_word(FUNC_CHK_FULL, caid_pool[0], prov_pool[0], srv_pool[0], '0, '1));
      send_word(check_word(FUNC_CHK_CP, caid_pool[0], prov_pool[0], srv_pool[0], '1, '0));
      send_word(check_word(FUNC_CHK_SRV, caid_pool[0], prov_pool[0], srv_pool[0], '0, '1));

      // table zero: two system ids, the all-ones provider, one service id
      send_word(entry_word(0, KIND_CAID, 0, {8'hff, caid_pool[0]}));
      send_word(entry_word(0, KIND_CAID, 1, {8'h00, caid_pool[1]}));
      send_word(entry_word(0, KIND_PROV, 0, '1));
      send_word(entry_word(0, KIND_SRV, 0, {8'h5a, srv_pool[0]}));
      send_word(entry_word(0, KIND_NONE, LIST_DEPTH - 1, '1));
      send_word(length_word(0, KIND_CAID, 2));
      send_word(length_word(0, KIND_PROV, 1));
      send_word(length_word(0, KIND_SRV, 1));
      send_word(length_word(0, KIND_NONE, LEN_LAST));

      // allow hit, service miss, deny hit, deny skipped on a table with services, service check hit
      send_word(check_word(FUNC_CHK_FULL, caid_pool[1], '1, srv_pool[0], MASK_W'(1), '0));
      send_word(check_word(FUNC_CHK_FULL, caid_pool[1], '1, ~srv_pool[0], MASK_W'(1), '0));
      send_word(check_word(FUNC_CHK_FULL, caid_pool[0], '1, srv_pool[0], '0, MASK_W'(1)));
      send_word(check_word(FUNC_CHK_CP, caid_pool[0], '1, srv_pool[0], '0, MASK_W'(1)));
      send_word(check_word(FUNC_CHK_SRV, caid_pool[1], '1, srv_pool[0], MASK_W'(1), '0));

      // last table holds a service list only, skipped by the caid/provider walk but hit by the full check
      send_word(entry_word(TABLE_COUNT - 1, KIND_SRV, 0, '1));
      send_word(length_word(TABLE_COUNT - 1, KIND_SRV, 1));
      send_word(check_word(FUNC_CHK_CP, '0, '0, '1, MASK_W'(1) << (TABLE_COUNT - 1), '0));
      send_word(check_word(FUNC_CHK_FULL, '0, '0, '1, MASK_W'(1) << (TABLE_COUNT - 1), '0));

      // unused func codes answer zero
      for (int f = FUNC_CHK_SRV + 1; f <= FUNC_LAST; f++) begin
         send_word(check_word(FUNC_W'(f), '1, '1, '1, '1, '1));
      end
      wait_quiet();

      // random phase: table loads, checks against them, and some noise
      work_done  = 0;
      next_pause = PAUSE_EVERY;
      while (work_done < WORK_ITEMS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3:   program_table();
            17, 18, 19:   send_noise();
            default:      send_word(random_check());
         endcase
         if (work_done >= next_pause) begin
            wait_quiet();
            next_pause += PAUSE_EVERY;
         end
      end

      // drain, then watch a little longer for stray strobes
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (verdict_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/sidam_pkg.sv
rtl/sidam_ram.sv
rtl/sidam_match.sv
rtl/service_id_acl_match.sv
tb/acl_verdict_checker.sv
tb/tb_top.sv
